// File: src/mks_pkg.sv
// Shared constants for the matrix keypad scanner: geometry, field widths,
// scan phase codes and configuration register indexes. No dependencies.
package mks_pkg;

    localparam int ROWS = 4;
    localparam int COLS = 4;

    localparam int RowW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ColW = (COLS > 1) ? $clog2(COLS) : 1;

    localparam int DriveW   = 4;
    localparam int LevelW   = 4;
    localparam int KeyW     = 5;
    localparam int SettleW  = 10;
    localparam int DebW     = 20;
    localparam int TimerW   = 20;
    localparam int PhaseW   = 3;
    localparam int CfgAddrW = 1;
    localparam int CfgDataW = 20;

    localparam logic [SettleW-1:0] SETTLE_RESET   = SettleW'(10);
    localparam logic [DebW-1:0]    DEBOUNCE_RESET = DebW'(20000);

    localparam logic [PhaseW-1:0] PH_SETTLE  = 3'd0;
    localparam logic [PhaseW-1:0] PH_SCAN    = 3'd1;
    localparam logic [PhaseW-1:0] PH_PRESS   = 3'd2;
    localparam logic [PhaseW-1:0] PH_HOLD    = 3'd3;
    localparam logic [PhaseW-1:0] PH_RELEASE = 3'd4;

    localparam logic [CfgAddrW-1:0] REG_SETTLE   = 1'd0;
    localparam logic [CfgAddrW-1:0] REG_DEBOUNCE = 1'd1;

endpackage

// File: src/matrix_keypad_scanner_core.sv
// Top level of the debounced matrix keypad scanner: scan state machine,
// configuration registers and the result register. Depends on mks_pkg.
//
// Each accepted input transfer is one timer tick carrying the sampled column
// levels, and each one yields exactly one result: the row drive in force on
// that tick, a pass-complete flag and the key found in the completed pass.
// The block takes one tick per clock cycle unless m_ready stalls it; the scan state
// machine and its wait timer advance in the same cycle the tick is taken, and the
// result sits in an output register, so a new tick is accepted whenever that register
// is empty or being drained. The user must write settle and debounce lengths through
// the configuration port only while the block is idle; the block does not enforce it.
module matrix_keypad_scanner_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [mks_pkg::CfgAddrW-1:0]  cfg_addr,
    input  logic [mks_pkg::CfgDataW-1:0]  cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mks_pkg::LevelW-1:0]    s_col_levels,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mks_pkg::DriveW-1:0]    m_row_drive,
    output logic                          m_scan_done,
    output logic [mks_pkg::KeyW-1:0]      m_key_code
);

    logic [mks_pkg::SettleW-1:0] settle_reg;
    logic [mks_pkg::DebW-1:0]    debounce_reg;

    logic [mks_pkg::PhaseW-1:0]  phase_reg, phase_next;
    logic [mks_pkg::RowW-1:0]    row_reg, row_next;
    logic [mks_pkg::ColW-1:0]    col_reg, col_next;
    logic [mks_pkg::TimerW-1:0]  timer_reg, timer_next;
    logic [mks_pkg::KeyW-1:0]    latched_reg, latched_next;

    logic                        valid_reg;
    logic [mks_pkg::DriveW-1:0]  drive_reg;
    logic                        done_reg;
    logic [mks_pkg::KeyW-1:0]    code_reg;

    logic                        accept;
    logic                        advance;
    logic                        col_low;
    logic [7:0]                  col_ext;
    logic [mks_pkg::DriveW-1:0]  drive;
    logic                        done;
    logic [mks_pkg::KeyW-1:0]    code;
    logic [mks_pkg::KeyW-1:0]    key_calc;
    logic [mks_pkg::TimerW-1:0]  timer_inc;

    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Columns beyond the input read as high; rows beyond the output drive nothing.
    assign col_ext = {4'hF, s_col_levels};
    assign col_low = !col_ext[3'(col_reg)];
    assign drive   = mks_pkg::DriveW'(~(8'd1 << row_reg));

    assign timer_inc = timer_reg + 1'b1;
    assign key_calc  = mks_pkg::KeyW'(mks_pkg::ROWS * mks_pkg::COLS
                                      - int'(row_reg) * mks_pkg::COLS - int'(col_reg));

    always_comb begin
        phase_next   = phase_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        timer_next   = timer_reg;
        latched_next = latched_reg;
        advance      = 1'b0;
        done         = 1'b0;
        code         = '0;

        unique case (phase_reg)
            mks_pkg::PH_SETTLE: begin
                if (timer_reg >= mks_pkg::TimerW'(settle_reg)) begin
                    timer_next = '0;
                    col_next   = '0;
                    phase_next = mks_pkg::PH_SCAN;
                end else begin
                    timer_next = timer_inc;
                end
            end
            mks_pkg::PH_SCAN: begin
                if (col_low) begin
                    timer_next = '0;
                    phase_next = mks_pkg::PH_PRESS;
                end else begin
                    advance = 1'b1;
                end
            end
            mks_pkg::PH_PRESS: begin
                if (timer_reg >= debounce_reg) begin
                    timer_next = '0;
                    if (col_low) begin
                        latched_next = key_calc;
                        phase_next   = mks_pkg::PH_HOLD;
                    end else begin
                        advance = 1'b1;
                    end
                end else begin
                    timer_next = timer_inc;
                end
            end
            mks_pkg::PH_HOLD: begin
                if (!col_low) begin
                    timer_next = '0;
                    phase_next = mks_pkg::PH_RELEASE;
                end
            end
            mks_pkg::PH_RELEASE: begin
                if (timer_reg >= debounce_reg) begin
                    timer_next = '0;
                    advance    = 1'b1;
                end else begin
                    timer_next = timer_inc;
                end
            end
            default: begin
                timer_next = '0;
                phase_next = mks_pkg::PH_SETTLE;
            end
        endcase

        // Step to the next column, the next row, or close out the pass.
        if (advance) begin
            if (int'(col_reg) + 1 < mks_pkg::COLS) begin
                col_next   = col_reg + 1'b1;
                phase_next = mks_pkg::PH_SCAN;
            end else begin
                col_next   = '0;
                timer_next = '0;
                phase_next = mks_pkg::PH_SETTLE;
                if (int'(row_reg) + 1 < mks_pkg::ROWS) begin
                    row_next = row_reg + 1'b1;
                end else begin
                    done         = 1'b1;
                    code         = latched_reg;
                    latched_next = '0;
                    row_next     = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg   <= mks_pkg::SETTLE_RESET;
            debounce_reg <= mks_pkg::DEBOUNCE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                mks_pkg::REG_SETTLE:   settle_reg   <= cfg_wdata[mks_pkg::SettleW-1:0];
                mks_pkg::REG_DEBOUNCE: debounce_reg <= cfg_wdata[mks_pkg::DebW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= mks_pkg::PH_SETTLE;
            row_reg     <= '0;
            col_reg     <= '0;
            timer_reg   <= '0;
            latched_reg <= '0;
            valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg   <= phase_next;
                row_reg     <= row_next;
                col_reg     <= col_next;
                timer_reg   <= timer_next;
                latched_reg <= latched_next;
                valid_reg   <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            drive_reg <= drive;
            done_reg  <= done;
            code_reg  <= code;
        end
    end

    assign m_valid     = valid_reg;
    assign m_row_drive = drive_reg;
    assign m_scan_done = done_reg;
    assign m_key_code  = code_reg;

    // A key code is only reported on the tick that closes a pass.
    a_code_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_scan_done |-> m_key_code == '0)
        else $error("key code reported outside a completed pass");

    // Exactly one row is driven low on every result tick.
    a_one_row_driven: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones(m_row_drive) == mks_pkg::DriveW - 1)
        else $error("row drive does not select exactly one row");

    // Scan state only moves when a tick is transferred.
    a_state_holds_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(timer_reg) && $stable(phase_reg) && $stable(row_reg))
        else $error("scan state changed without an input transfer");

endmodule
